FILE: sv/lpc_pkg.sv
// shared types and constants of the line printer controller
package lpc_pkg;

  typedef enum logic [1:0] {
    OP_FUNC   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_STATUS = 2'd2,
    OP_DISC   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_STATUS = 2'd2,
    KIND_FLUSH  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_OUTPUT  = 2'd1,
    MODE_DISCARD = 2'd2,
    MODE_STATUS  = 2'd3
  } mode_t;

  // configuration register indexes
  localparam logic [0:0] CFG_IDX_3555  = 1'b0;
  localparam logic [0:0] CFG_IDX_ASCII = 1'b1;

  // function codes
  localparam logic [11:0] FC_RELEASE   = 12'o0000;
  localparam logic [11:0] FC_NL_A      = 12'o0001;
  localparam logic [11:0] FC_NL_TWO    = 12'o0002;
  localparam logic [11:0] FC_NL_B      = 12'o0003;
  localparam logic [11:0] FC_FORM_FEED = 12'o0004;
  localparam logic [11:0] FC_OUT_EN    = 12'o1600;
  localparam logic [11:0] FC_STAT_REQ  = 12'o1300;
  localparam logic [11:0] FC_FILL_MEM  = 12'o0012;
  localparam logic [11:0] FC_NEW_BASE  = 12'o0020;
  localparam logic [11:0] FC_OLD_BASE  = 12'o0030;

  // carriage characters
  localparam logic [7:0] CH_NEWLINE   = 8'o012;
  localparam logic [7:0] CH_FORM_FEED = 8'o014;

  // status word bits
  localparam logic [11:0] ST_READY   = 12'o0001;
  localparam logic [11:0] ST_RDY_INT = 12'o0200;
  localparam logic [11:0] ST_END_INT = 12'o0400;

  // one decoded item: up to two results, the second always a character
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  ch0;
    logic [7:0]  ch1;
    logic        disp;
    logic [11:0] status;
    logic        acc;
    logic        int_line;
    logic        two;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: sv/lpc_front.sv
// front end: takes requests, keeps controller state, builds result jobs
module lpc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [0:0]       cfg_index,
  input  logic             cfg_data,
  input  logic             in_valid,
  input  logic [1:0]       opcode,
  input  logic [11:0]      func_code,
  input  logic [11:0]      data_word,
  input  lpc_pkg::q_stat_t q_stat,
  output logic             in_stall,
  output logic             push,
  output lpc_pkg::job_t    job
);

  logic controller_is_3555, printer_is_ascii;
  logic ready_int_pending, end_int_pending, ready_int_enabled, end_int_enabled;
  logic fill_image_armed, has_printed, keep_interrupt;
  lpc_pkg::mode_t transfer_mode;

  logic ready_int_pending_next, end_int_pending_next;
  logic ready_int_enabled_next, end_int_enabled_next;
  logic fill_image_armed_next, has_printed_next, keep_interrupt_next;
  lpc_pkg::mode_t transfer_mode_next;

  lpc_pkg::op_t op;
  logic [11:0]  sel_r, rel_r, sel_e, rel_e, base;
  logic         accept;

  assign op       = lpc_pkg::op_t'(opcode);
  assign in_stall = q_stat.full;
  assign accept   = in_valid & ~q_stat.full;
  assign push     = accept;

  // interrupt select/release codes move with the code set
  assign base  = controller_is_3555 ? lpc_pkg::FC_NEW_BASE : lpc_pkg::FC_OLD_BASE;
  assign sel_r = base;
  assign rel_r = base + 12'd1;
  assign sel_e = base + 12'd2;
  assign rel_e = base + 12'd3;

  // transfer mode
  always_comb begin
    transfer_mode_next = transfer_mode;
    case (op)
      lpc_pkg::OP_FUNC: begin
        if (func_code == lpc_pkg::FC_OUT_EN) begin
          transfer_mode_next = fill_image_armed ? lpc_pkg::MODE_DISCARD
                                                : lpc_pkg::MODE_OUTPUT;
        end else if (func_code == lpc_pkg::FC_STAT_REQ) begin
          transfer_mode_next = lpc_pkg::MODE_STATUS;
        end
      end
      lpc_pkg::OP_STATUS: begin
        if (transfer_mode == lpc_pkg::MODE_STATUS) transfer_mode_next = lpc_pkg::MODE_IDLE;
      end
      lpc_pkg::OP_DISC: begin
        if (transfer_mode == lpc_pkg::MODE_OUTPUT) transfer_mode_next = lpc_pkg::MODE_IDLE;
      end
      default: ;
    endcase
  end

  // flags and results
  always_comb begin
    ready_int_pending_next = ready_int_pending;
    end_int_pending_next   = end_int_pending;
    ready_int_enabled_next = ready_int_enabled;
    end_int_enabled_next   = end_int_enabled;
    fill_image_armed_next  = fill_image_armed;
    has_printed_next       = has_printed;
    keep_interrupt_next    = keep_interrupt;
    job = '{kind: lpc_pkg::KIND_ACK, ch0: 8'd0, ch1: 8'd0, disp: 1'b0,
            status: 12'd0, acc: 1'b0, int_line: 1'b0, two: 1'b0};
    case (op)
      lpc_pkg::OP_FUNC: begin
        case (func_code)
          lpc_pkg::FC_RELEASE: begin
            ready_int_pending_next = 1'b0;
            end_int_pending_next   = 1'b0;
            if (has_printed) begin
              has_printed_next = 1'b0;
              job.kind         = lpc_pkg::KIND_FLUSH;
            end
          end
          lpc_pkg::FC_NL_A, lpc_pkg::FC_NL_B: begin
            job.kind = lpc_pkg::KIND_CHAR;
            job.ch0  = lpc_pkg::CH_NEWLINE;
          end
          lpc_pkg::FC_NL_TWO: begin
            job.kind = lpc_pkg::KIND_CHAR;
            job.ch0  = lpc_pkg::CH_NEWLINE;
            job.ch1  = lpc_pkg::CH_NEWLINE;
            job.two  = 1'b1;
          end
          lpc_pkg::FC_FORM_FEED: begin
            job.kind = lpc_pkg::KIND_CHAR;
            job.ch0  = lpc_pkg::CH_FORM_FEED;
          end
          lpc_pkg::FC_OUT_EN: begin
            fill_image_armed_next  = 1'b0;
            ready_int_pending_next = ready_int_enabled;
            end_int_pending_next   = end_int_enabled;
            job.acc                = 1'b1;
          end
          lpc_pkg::FC_STAT_REQ: begin
            job.acc = 1'b1;
          end
          default: begin
            if (controller_is_3555 && func_code == lpc_pkg::FC_FILL_MEM) begin
              fill_image_armed_next = 1'b1;
            end
            if (func_code == sel_r) begin
              ready_int_enabled_next = 1'b1;
              ready_int_pending_next = keep_interrupt;
              keep_interrupt_next    = 1'b0;
            end else if (func_code == rel_r) begin
              ready_int_enabled_next = 1'b0;
              ready_int_pending_next = 1'b0;
            end else if (func_code == sel_e) begin
              end_int_enabled_next = 1'b1;
              end_int_pending_next = keep_interrupt;
              keep_interrupt_next  = 1'b0;
            end else if (func_code == rel_e) begin
              end_int_enabled_next = 1'b0;
              end_int_pending_next = 1'b0;
            end
          end
        endcase
      end
      lpc_pkg::OP_WRITE: begin
        if (transfer_mode == lpc_pkg::MODE_OUTPUT) begin
          job.kind = lpc_pkg::KIND_CHAR;
          if (printer_is_ascii) begin
            job.ch0 = data_word[7:0];
          end else begin
            job.ch0  = {2'b00, data_word[11:6]};
            job.ch1  = {2'b00, data_word[5:0]};
            job.disp = 1'b1;
            job.two  = 1'b1;
          end
          has_printed_next    = 1'b1;
          keep_interrupt_next = 1'b1;
        end
      end
      lpc_pkg::OP_STATUS: begin
        if (transfer_mode == lpc_pkg::MODE_STATUS) begin
          job.kind   = lpc_pkg::KIND_STATUS;
          job.status = lpc_pkg::ST_READY
                     | (ready_int_pending ? lpc_pkg::ST_RDY_INT : 12'd0)
                     | (end_int_pending ? lpc_pkg::ST_END_INT : 12'd0);
        end
      end
      lpc_pkg::OP_DISC: begin
        if (transfer_mode == lpc_pkg::MODE_OUTPUT) begin
          job.kind = lpc_pkg::KIND_CHAR;
          job.ch0  = lpc_pkg::CH_NEWLINE;
        end
      end
      default: ;
    endcase
    job.int_line = ready_int_pending_next | end_int_pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      controller_is_3555 <= 1'b1;
      printer_is_ascii   <= 1'b0;
      ready_int_pending  <= 1'b0;
      end_int_pending    <= 1'b0;
      ready_int_enabled  <= 1'b0;
      end_int_enabled    <= 1'b0;
      fill_image_armed   <= 1'b0;
      has_printed        <= 1'b0;
      keep_interrupt     <= 1'b0;
      transfer_mode      <= lpc_pkg::MODE_IDLE;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == lpc_pkg::CFG_IDX_3555) controller_is_3555 <= cfg_data;
        if (cfg_index == lpc_pkg::CFG_IDX_ASCII) printer_is_ascii <= cfg_data;
      end
      if (accept) begin
        ready_int_pending <= ready_int_pending_next;
        end_int_pending   <= end_int_pending_next;
        ready_int_enabled <= ready_int_enabled_next;
        end_int_enabled   <= end_int_enabled_next;
        fill_image_armed  <= fill_image_armed_next;
        has_printed       <= has_printed_next;
        keep_interrupt    <= keep_interrupt_next;
        transfer_mode     <= transfer_mode_next;
      end
    end
  end

endmodule

FILE: sv/lpc_queue.sv
// short job queue between front and back end
module lpc_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lpc_pkg::job_t    push_job,
  input  logic             pop,
  output lpc_pkg::job_t    pop_job,
  output lpc_pkg::q_stat_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  lpc_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign q_stat.full  = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push & ~q_stat.full;
  assign do_pop       = pop & ~q_stat.empty;
  assign pop_job      = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == LAST_PTR) ? '0 : wptr + PW'(1);
      if (do_pop) rptr <= (rptr == LAST_PTR) ? '0 : rptr + PW'(1);
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule

FILE: sv/lpc_back.sv
// back end: output register that plays each job out as one or two results
module lpc_back (
  input  logic             clk,
  input  logic             rst,
  input  lpc_pkg::q_stat_t q_stat,
  input  lpc_pkg::job_t    q_job,
  input  logic             out_stall,
  output logic             pop,
  output logic             out_valid,
  output logic [1:0]       result_kind,
  output logic [7:0]       char_value,
  output logic             char_is_display,
  output logic [11:0]      status_word,
  output logic             func_accepted,
  output logic             interrupt_line,
  output logic             last
);

  lpc_pkg::job_t cur;
  logic          busy, phase;
  logic          is_last, take, done, load;

  assign is_last = phase | ~cur.two;
  assign take    = busy & ~out_stall;
  assign done    = take & is_last;
  assign load    = (~busy | done) & ~q_stat.empty;
  assign pop     = load;

  always_ff @(posedge clk) begin
    if (load) cur <= q_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (load) begin
      busy  <= 1'b1;
      phase <= 1'b0;
    end else if (done) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (take) begin
      phase <= 1'b1;
    end
  end

  // second result of a pair is always a character
  assign out_valid       = busy;
  assign result_kind     = phase ? lpc_pkg::KIND_CHAR : cur.kind;
  assign char_value      = phase ? cur.ch1 : cur.ch0;
  assign char_is_display = cur.disp;
  assign status_word     = cur.status;
  assign func_accepted   = cur.acc;
  assign interrupt_line  = cur.int_line;
  assign last            = is_last;

endmodule

FILE: sv/line_printer_controller.sv
// top level of the line printer controller
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_stall   | opcode, func_code, data_word
//  out      | out_valid / out_stall | result_kind, char_value, char_is_display,
//           |                       | status_word, func_accepted,
//           |                       | interrupt_line, last
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  one request per cycle enters while the queue is not full; the front end updates
//  all controller state in the accept cycle, so the next request follows at once
//  the output register gives one result per cycle while out_stall is low: a
//  request with two results (double newline, word on the display-code printer)
//  holds it until both are taken, so the queue of QUEUE_DEPTH jobs sets how long
//  the input can run ahead; each job passes the queue, then the output register
//  reset (rst, synchronous) empties the queue and resets the controller state
//  in_stall rises only when the queue is full; out_stall holds the result
module line_printer_controller #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [11:0] func_code,
  input  logic [11:0] data_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  char_value,
  output logic        char_is_display,
  output logic [11:0] status_word,
  output logic        func_accepted,
  output logic        interrupt_line,
  output logic        last
);

  lpc_pkg::job_t    push_job, pop_job;
  lpc_pkg::q_stat_t q_stat;
  logic             push, pop;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  // decode and state
  lpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .func_code (func_code),
    .data_word (data_word),
    .q_stat    (q_stat),
    .in_stall  (in_stall),
    .push      (push),
    .job       (push_job)
  );

  // decouples a stalled output from the input side
  lpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  // result sequencing
  lpc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_stat          (q_stat),
    .q_job           (pop_job),
    .out_stall       (out_stall),
    .pop             (pop),
    .out_valid       (out_valid),
    .result_kind     (result_kind),
    .char_value      (char_value),
    .char_is_display (char_is_display),
    .status_word     (status_word),
    .func_accepted   (func_accepted),
    .interrupt_line  (interrupt_line),
    .last            (last)
  );

  // only character results carry a character
  a_char_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != lpc_pkg::KIND_CHAR |-> char_value == 8'd0 && !char_is_display)
    else $error("character field set on a non-character result");

  // a transfer start is a single acknowledge
  a_acc_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && func_accepted |-> result_kind == lpc_pkg::KIND_ACK && last)
    else $error("transfer start not a single acknowledge");

  // status words come only with status results and always show ready
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_word != 12'd0 |->
      result_kind == lpc_pkg::KIND_STATUS && status_word[0] && last)
    else $error("bad status word");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

FILE: tb/tb_line_printer_controller.sv
// testbench of the line printer controller: directed and random requests against a predictor
`timescale 1ns / 100ps

module tb_line_printer_controller;

  // one result as seen on the output channel
  typedef struct packed {
    lpc_pkg::kind_t kind;
    logic [7:0]     ch;
    logic           disp;
    logic [11:0]    status;
    logic           acc;
    logic           intl;
    logic           last;
  } print_result_t;

  localparam int HOLD_CYCLES = 80;

  // vfu codes and a code no set knows
  localparam logic [11:0] FC_VFU_A   = 12'o0005;
  localparam logic [11:0] FC_VFU_B   = 12'o0006;
  localparam logic [11:0] FC_VFU_C   = 12'o1700;
  localparam logic [11:0] FC_UNKNOWN = 12'o7777;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  // block inputs, all known from time zero
  logic        cfg_valid = 1'b0;
  logic [0:0]  cfg_index = lpc_pkg::CFG_IDX_3555;
  logic        cfg_data  = 1'b0;
  logic        in_valid  = 1'b0;
  logic [1:0]  opcode    = lpc_pkg::OP_FUNC;
  logic [11:0] func_code = '0;
  logic [11:0] data_word = '0;
  logic        out_stall = 1'b0;

  // block outputs
  logic        cfg_ready;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  result_kind;
  logic [7:0]  char_value;
  logic        char_is_display;
  logic [11:0] status_word;
  logic        func_accepted;
  logic        interrupt_line;
  logic        last;

  line_printer_controller dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .func_code      (func_code),
    .data_word      (data_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .char_value     (char_value),
    .char_is_display(char_is_display),
    .status_word    (status_word),
    .func_accepted  (func_accepted),
    .interrupt_line (interrupt_line),
    .last           (last)
  );

  // mirror of the controller state, updated on accepted requests and config writes
  bit             cfg_3555  = 1'b1;
  bit             cfg_ascii = 1'b0;
  bit             rdy_pend, end_pend, rdy_en, end_en;
  bit             fill_armed, printed, keep_int;
  lpc_pkg::mode_t xfer_mode = lpc_pkg::MODE_IDLE;

  // results still owed by the block, oldest first
  print_result_t awaited_results[$];

  // idle rates in percent and bookkeeping
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int errors        = 0;
  int requests_sent = 0;
  int results_seen  = 0;
  int cfg_writes    = 0;
  int holds_done    = 0;

  function automatic print_result_t char_result(input logic [7:0] ch, input logic disp);
    print_result_t r;
    r      = '0;
    r.kind = lpc_pkg::KIND_CHAR;
    r.ch   = ch;
    r.disp = disp;
    return r;
  endfunction

  // expected results of one accepted request, pushed in order
  task automatic decode_request(input logic [1:0] op, input logic [11:0] fc,
                                input logic [11:0] dw);
    print_result_t res [2];
    int            n;
    logic [11:0]   base;
    n      = 1;
    res[0] = '0;
    res[1] = '0;
    case (op)
      lpc_pkg::OP_FUNC: begin
        case (fc)
          lpc_pkg::FC_RELEASE: begin
            rdy_pend = 1'b0;
            end_pend = 1'b0;
            // release after printing asks for a flush
            if (printed) begin
              printed     = 1'b0;
              res[0].kind = lpc_pkg::KIND_FLUSH;
            end
          end
          lpc_pkg::FC_NL_A, lpc_pkg::FC_NL_B: res[0] = char_result(lpc_pkg::CH_NEWLINE, 1'b0);
          lpc_pkg::FC_NL_TWO: begin
            res[0] = char_result(lpc_pkg::CH_NEWLINE, 1'b0);
            res[1] = char_result(lpc_pkg::CH_NEWLINE, 1'b0);
            n      = 2;
          end
          lpc_pkg::FC_FORM_FEED: res[0] = char_result(lpc_pkg::CH_FORM_FEED, 1'b0);
          lpc_pkg::FC_OUT_EN: begin
            if (fill_armed) begin
              xfer_mode  = lpc_pkg::MODE_DISCARD;
              fill_armed = 1'b0;
            end else begin
              xfer_mode = lpc_pkg::MODE_OUTPUT;
            end
            rdy_pend   = rdy_en;
            end_pend   = end_en;
            res[0].acc = 1'b1;
          end
          lpc_pkg::FC_STAT_REQ: begin
            xfer_mode  = lpc_pkg::MODE_STATUS;
            res[0].acc = 1'b1;
          end
          default: begin
            // interrupt select/release codes depend on the code set
            base = cfg_3555 ? lpc_pkg::FC_NEW_BASE : lpc_pkg::FC_OLD_BASE;
            if (cfg_3555 && fc == lpc_pkg::FC_FILL_MEM) fill_armed = 1'b1;
            if (fc == base) begin
              rdy_en   = 1'b1;
              rdy_pend = keep_int;
              keep_int = 1'b0;
            end else if (fc == base + 12'd1) begin
              rdy_en   = 1'b0;
              rdy_pend = 1'b0;
            end else if (fc == base + 12'd2) begin
              end_en   = 1'b1;
              end_pend = keep_int;
              keep_int = 1'b0;
            end else if (fc == base + 12'd3) begin
              end_en   = 1'b0;
              end_pend = 1'b0;
            end
          end
        endcase
      end
      lpc_pkg::OP_WRITE: begin
        if (xfer_mode == lpc_pkg::MODE_OUTPUT) begin
          if (cfg_ascii) begin
            res[0] = char_result(dw[7:0], 1'b0);
          end else begin
            res[0] = char_result({2'b00, dw[11:6]}, 1'b1);
            res[1] = char_result({2'b00, dw[5:0]}, 1'b1);
            n      = 2;
          end
          printed  = 1'b1;
          keep_int = 1'b1;
        end
      end
      lpc_pkg::OP_STATUS: begin
        if (xfer_mode == lpc_pkg::MODE_STATUS) begin
          res[0].kind   = lpc_pkg::KIND_STATUS;
          res[0].status = lpc_pkg::ST_READY
                        | (rdy_pend ? lpc_pkg::ST_RDY_INT : 12'd0)
                        | (end_pend ? lpc_pkg::ST_END_INT : 12'd0);
          xfer_mode     = lpc_pkg::MODE_IDLE;
        end
      end
      default: begin
        // disconnect ends an output transfer with a newline
        if (xfer_mode == lpc_pkg::MODE_OUTPUT) begin
          res[0]    = char_result(lpc_pkg::CH_NEWLINE, 1'b0);
          xfer_mode = lpc_pkg::MODE_IDLE;
        end
      end
    endcase
    for (int k = 0; k < n; k++) begin
      res[k].intl = rdy_pend | end_pend;
      res[k].last = (k == n - 1);
      awaited_results.push_back(res[k]);
    end
  endtask

  // monitor: config mirror, prediction of accepted requests, result check
  always @(posedge clk) begin
    print_result_t seen;
    print_result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lpc_pkg::CFG_IDX_3555) cfg_3555 = cfg_data;
        else cfg_ascii = cfg_data;
      end
      if (in_valid && !in_stall) decode_request(opcode, func_code, data_word);
      if (out_valid && !out_stall) begin
        results_seen++;
        seen.kind   = lpc_pkg::kind_t'(result_kind);
        seen.ch     = char_value;
        seen.disp   = char_is_display;
        seen.status = status_word;
        seen.acc    = func_accepted;
        seen.intl   = interrupt_line;
        seen.last   = last;
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display({"unexpected result: kind %0d char %0h disp %0b st %0h",
                      " acc %0b int %0b last %0b"},
                     seen.kind, seen.ch, seen.disp, seen.status, seen.acc, seen.intl,
                     seen.last);
        end else begin
          want = awaited_results.pop_front();
          if (seen.kind !== want.kind || seen.ch !== want.ch || seen.disp !== want.disp ||
              seen.status !== want.status || seen.acc !== want.acc ||
              seen.intl !== want.intl || seen.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display({"mismatch at %0t: expected kind %0d char %0h disp %0b st %0h",
                        " acc %0b int %0b last %0b"},
                       $realtime, want.kind, want.ch, want.disp, want.status, want.acc,
                       want.intl, want.last);
              $display({"                got      kind %0d char %0h disp %0b st %0h",
                        " acc %0b int %0b last %0b"},
                       seen.kind, seen.ch, seen.disp, seen.status, seen.acc, seen.intl,
                       seen.last);
            end
          end
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    int hold_left;
    int hold_seen;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // offer one request and wait until it is taken; unused fields carry noise
  task automatic send_request(input lpc_pkg::op_t op, input logic [11:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    func_code <= (op == lpc_pkg::OP_FUNC)  ? val : 12'($urandom_range(0, 4095));
    data_word <= (op == lpc_pkg::OP_WRITE) ? val : 12'($urandom_range(0, 4095));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  // stop offering and wait for every owed result
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [0:0] idx, input logic val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic set_config(input logic c3555, input logic ascii);
    cfg_write(lpc_pkg::CFG_IDX_3555, c3555);
    cfg_write(lpc_pkg::CFG_IDX_ASCII, ascii);
  endtask

  // every function code of the newer set and special cases on the reset settings
  task automatic test_directed_codes();
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_RELEASE);    // release with nothing printed
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_NL_A);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_NL_B);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_NL_TWO);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_FORM_FEED);
    send_request(lpc_pkg::OP_FUNC, FC_VFU_A);               // vfu codes do nothing
    send_request(lpc_pkg::OP_FUNC, FC_VFU_B);
    send_request(lpc_pkg::OP_FUNC, FC_VFU_C);
    send_request(lpc_pkg::OP_FUNC, FC_UNKNOWN);
    send_request(lpc_pkg::OP_WRITE, 12'o7777);              // word outside output mode
    send_request(lpc_pkg::OP_DISC, 12'd0);                  // disconnect outside output mode
    send_request(lpc_pkg::OP_STATUS, 12'd0);                // status read outside status mode
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_OUT_EN);
    send_request(lpc_pkg::OP_WRITE, 12'o0000);
    send_request(lpc_pkg::OP_WRITE, 12'o7777);
    send_request(lpc_pkg::OP_DISC, 12'd0);                  // trailing newline
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_NEW_BASE);   // select ready with keep set
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_NEW_BASE + 12'd2);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_STAT_REQ);
    send_request(lpc_pkg::OP_STATUS, 12'd0);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_RELEASE);    // release after printing flushes
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_FILL_MEM);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_OUT_EN);     // discard mode
    send_request(lpc_pkg::OP_WRITE, 12'o1234);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_NEW_BASE + 12'd1);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_NEW_BASE + 12'd3);
  endtask

  // older code set: its own interrupt codes, newer ones ignored
  task automatic test_old_code_set();
    set_config(1'b0, 1'b0);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_OUT_EN);
    send_request(lpc_pkg::OP_WRITE, 12'o4321);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_OLD_BASE);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_OLD_BASE + 12'd2);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_NEW_BASE);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_FILL_MEM);   // no fill memory in this set
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_OUT_EN);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_STAT_REQ);
    send_request(lpc_pkg::OP_STATUS, 12'd0);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_OLD_BASE + 12'd1);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_OLD_BASE + 12'd3);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_RELEASE);
  endtask

  // ascii printer: one byte per word
  task automatic test_ascii_printer();
    set_config(1'b1, 1'b1);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_OUT_EN);
    send_request(lpc_pkg::OP_WRITE, 12'h000);
    send_request(lpc_pkg::OP_WRITE, 12'hFFF);
    send_request(lpc_pkg::OP_WRITE, 12'h0FF);
    send_request(lpc_pkg::OP_WRITE, 12'hF00);
    send_request(lpc_pkg::OP_DISC, 12'd0);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_RELEASE);
  endtask

  // mostly well-formed sequences with random content, some noise
  task automatic test_random_traffic(input int n_items);
    int          stop_at;
    int          pick;
    logic [11:0] base;
    stop_at = requests_sent + n_items;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // print job, sometimes with fill memory first
        if ($urandom_range(0, 3) == 0) send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_FILL_MEM);
        send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_OUT_EN);
        repeat ($urandom_range(0, 6))
          send_request(lpc_pkg::OP_WRITE, 12'($urandom_range(0, 4095)));
        if ($urandom_range(0, 7) != 0) send_request(lpc_pkg::OP_DISC, 12'd0);
        if ($urandom_range(0, 1) == 0) send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_RELEASE);
      end else if (pick < 55) begin
        send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_STAT_REQ);
        repeat ($urandom_range(0, 2)) send_request(lpc_pkg::OP_STATUS, 12'd0);
      end else if (pick < 75) begin
        base = $urandom_range(0, 1) ? lpc_pkg::FC_NEW_BASE : lpc_pkg::FC_OLD_BASE;
        send_request(lpc_pkg::OP_FUNC, base + 12'($urandom_range(0, 3)));
      end else if (pick < 85) begin
        send_request(lpc_pkg::OP_FUNC, 12'($urandom_range(0, 6)));
      end else begin
        send_request(lpc_pkg::op_t'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)));
      end
    end
  endtask

  // receiver pauses fully and then stalls at random while the sender keeps offering
  task automatic test_backpressure();
    set_config(1'b0, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 20;
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_OUT_EN);
    hold_req++;
    holds_done++;
    repeat (30) send_request(lpc_pkg::OP_WRITE, 12'($urandom_range(0, 4095)));
    send_request(lpc_pkg::OP_DISC, 12'd0);
    wait_idle();
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_NL_TWO);
    send_request(lpc_pkg::OP_FUNC, lpc_pkg::FC_RELEASE);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 34;
    recv_idle_pct = 56;
    test_directed_codes();
    test_old_code_set();
    test_ascii_printer();

    // random phases, each on its own setting
    set_config(1'b1, 1'b0);
    test_random_traffic(280);
    set_config(1'b0, 1'b1);
    send_idle_pct = 56;
    recv_idle_pct = 34;
    test_random_traffic(280);
    set_config(1'b1, 1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(280);

    test_backpressure();

    wait_idle();
    repeat (10) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d config writes, %0d receiver hold-offs",
             requests_sent, results_seen, cfg_writes, holds_done);
    $display("both code sets and both printer types, with and without idling; %0d failures",
             errors);
    if (errors == 0) begin
      $display("tb_line_printer_controller OK");
    end else begin
      $display("tb_line_printer_controller NOT OK");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("timeout with %0d results still owed", awaited_results.size());
    $display("tb_line_printer_controller NOT OK");
    $finish;
  end

endmodule
